[design/hrp_pkg.sv]
// Package: payload types, state codes and match-text lookups for the HTTP request parser.
package hrp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_conn;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic        last_of_body;
    logic        is_post;
    logic [2:0]  route;
    logic [31:0] content_length;
    logic        compressed;
    logic        keep_open;
    logic [1:0]  verdict;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_REST    = 3'd2,
    PH_HEADERS = 3'd3,
    PH_BODY    = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    VS_NONE    = 4'd0,
    VS_NAME    = 4'd1,
    VS_LEN_WS  = 4'd2,
    VS_LEN_DIG = 4'd3,
    VS_ENC_WS  = 4'd4,
    VS_GZIP    = 4'd5,
    VS_DEFLATE = 4'd6,
    VS_CONN_WS = 4'd7,
    VS_CLOSE   = 4'd8
  } vstate_e;

  localparam logic [1:0] KIND_DESC = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  localparam logic [1:0] VERDICT_DISPATCH  = 2'd0;
  localparam logic [1:0] VERDICT_NOT_FOUND = 2'd1;
  localparam logic [1:0] VERDICT_TOO_LARGE = 2'd2;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd3;

  localparam logic [2:0] ROUTE_UNKNOWN = 3'd4;
  localparam logic [31:0] MAX_BODY_RESET = 32'd16777216;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_QM = 8'd63;

  localparam logic [8*4-1:0]  TXT_POST    = "POST";
  localparam logic [8*10-1:0] TXT_TRACES  = "/v1/traces";
  localparam logic [8*11-1:0] TXT_METRICS = "/v1/metrics";
  localparam logic [8*8-1:0]  TXT_LOGS    = "/v1/logs";
  localparam logic [8*15-1:0] TXT_PROC    = "/v1/procmetrics";
  localparam logic [8*15-1:0] TXT_CLEN    = "content-length:";
  localparam logic [8*17-1:0] TXT_CENC    = "content-encoding:";
  localparam logic [8*11-1:0] TXT_CONN    = "connection:";
  localparam logic [8*4-1:0]  TXT_GZIP    = "gzip";
  localparam logic [8*7-1:0]  TXT_DEFLATE = "deflate";
  localparam logic [8*5-1:0]  TXT_CLOSE   = "close";

  function automatic logic [4:0] route_len(input logic [1:0] k);
    case (k)
      2'd0:    route_len = 5'd10;
      2'd1:    route_len = 5'd11;
      2'd2:    route_len = 5'd8;
      default: route_len = 5'd15;
    endcase
  endfunction

  // Character at pos of route k; only meaningful when pos < route_len(k).
  function automatic logic [7:0] route_char(input logic [1:0] k, input logic [4:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (k)
      2'd0:    if (pos < 5'd10) ch = TXT_TRACES[8*(9 - 32'(pos)) +: 8];
      2'd1:    if (pos < 5'd11) ch = TXT_METRICS[8*(10 - 32'(pos)) +: 8];
      2'd2:    if (pos < 5'd8)  ch = TXT_LOGS[8*(7 - 32'(pos)) +: 8];
      default: if (pos < 5'd15) ch = TXT_PROC[8*(14 - 32'(pos)) +: 8];
    endcase
    return ch;
  endfunction

  function automatic logic [4:0] name_len(input logic [1:0] k);
    case (k)
      2'd0:    name_len = 5'd15;
      2'd1:    name_len = 5'd17;
      default: name_len = 5'd11;
    endcase
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] k, input logic [4:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (k)
      2'd0:    if (pos < 5'd15) ch = TXT_CLEN[8*(14 - 32'(pos)) +: 8];
      2'd1:    if (pos < 5'd17) ch = TXT_CENC[8*(16 - 32'(pos)) +: 8];
      default: if (pos < 5'd11) ch = TXT_CONN[8*(10 - 32'(pos)) +: 8];
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] post_char(input logic [2:0] pos);
    return (pos < 3'd4) ? TXT_POST[8*(3 - 32'(pos)) +: 8] : 8'd0;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

endpackage

[design/hrp_stream_if.sv]
// Interface: valid/ready channel carrying one payload word.
interface hrp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/http_request_header_parser.sv]
// Top level: byte-serial HTTP/1.1 request header parser with body forwarding.
//
// Channels: in_i takes one connection byte per word plus new_conn, which
// restarts the parser with that byte as the first of a fresh connection.
// out_o delivers at most one word per input byte: a request descriptor at the
// blank line ending the headers, one word per body byte (last one marked), or
// a drop word when the connection is rejected. cfg_i writes max_body_bytes.
// A result is registered onto out_o in the cycle after its input byte is taken.
// Throughput: one byte per cycle unless stalled; the per-byte match update is
// a single step between the parser state registers and the output register,
// and the widest path is the content-length multiply-by-ten with saturation.
// Stall: in_i.ready stays high while the output register is empty or is
// being drained in the same cycle, so a stalled receiver holds the pending
// word and back-pressures the input by exactly one word.
// Reset: parser returns to the request-line phase, output empties,
// max_body_bytes returns to 16777216. cfg_i is always ready.
// All bytes are swallowed until new_conn after a drop or a non-keep-alive-POST request.
module http_request_header_parser
  import hrp_pkg::*;
#(
  parameter int HEADER_LIMIT = 16384,
  parameter int LINE_LIMIT   = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  hrp_stream_if.sink   in_i,
  hrp_stream_if.sink   cfg_i,
  hrp_stream_if.source out_o
);

  localparam int HCW = $clog2(HEADER_LIMIT + 5);
  localparam int LCW = $clog2(LINE_LIMIT + 2);

  // Parser state
  phase_e      phase_q, phase_d;
  logic [23:0] recent_q, recent_d;
  logic [HCW-1:0] hcnt_q, hcnt_d;
  logic [LCW-1:0] lcnt_q, lcnt_d;
  logic [2:0]  mm_q, mm_d;
  logic [3:0]  rc_q, rc_d;
  logic [4:0]  pp_q, pp_d;
  logic [2:0]  hmask_q, hmask_d;
  logic [4:0]  hpos_q, hpos_d;
  vstate_e     vs_q, vs_d;
  logic [31:0] acc_q, acc_d;
  logic        keep_q, keep_d;
  logic        comp_q, comp_d;
  logic        post_q, post_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] max_q;

  // Output register
  logic      ovalid_q;
  out_word_t odata_q;
  out_word_t res_d;
  logic      res_v;

  logic accept;
  assign in_i.ready  = !ovalid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

  always_comb begin
    logic [7:0]  c, lc, prev;
    logic        ws, dig, restart, fin2, fin4, stop;
    logic [HCW-1:0] sep, hlen;
    logic [LCW-1:0] llen;
    logic [31:0] len;
    logic [2:0]  rt, mask;
    logic [4:0]  pos;
    logic [35:0] prod;
    logic [4:0]  wlen;
    logic [7:0]  wch;

    c    = in_i.data.data_byte;
    lc   = to_lower(c);
    ws   = (c == CH_SP) || (c == CH_TAB);
    dig  = (c >= 8'd48) && (c <= 8'd57);
    restart = 1'b0;
    stop = 1'b0;
    sep  = '0; hlen = '0; llen = '0; len = '0; rt = ROUTE_UNKNOWN;
    mask = '0; pos = '0; prod = '0; wlen = '0; wch = '0;
    res_v = 1'b0;
    res_d = '0;

    phase_d = phase_q; recent_d = recent_q; hcnt_d = hcnt_q; lcnt_d = lcnt_q;
    mm_d = mm_q; rc_d = rc_q; pp_d = pp_q; hmask_d = hmask_q; hpos_d = hpos_q;
    vs_d = vs_q; acc_d = acc_q; keep_d = keep_q; comp_d = comp_q; post_d = post_q;
    rem_d = rem_q;

    if (in_i.data.new_conn) begin
      phase_d = PH_METHOD; recent_d = '0; hcnt_d = '0; lcnt_d = '0; mm_d = '0;
      rc_d = 4'hF; pp_d = '0; hmask_d = '0; hpos_d = '0; vs_d = VS_NONE;
      acc_d = '0; keep_d = 1'b1; comp_d = 1'b0; post_d = 1'b0; rem_d = '0;
    end
    prev = recent_d[7:0];

    case (phase_d)
      PH_METHOD, PH_PATH, PH_REST, PH_HEADERS: begin
        hcnt_d = hcnt_d + 1'b1;
        fin2 = (phase_d == PH_HEADERS) && (c == CH_LF) && (prev == CH_LF);
        fin4 = (phase_d == PH_HEADERS) && (c == CH_LF) && (prev == CH_CR) &&
               (recent_d[15:8] == CH_LF) && (recent_d[23:16] == CH_CR);
        if (fin2 || fin4) begin
          sep  = fin2 ? HCW'(2) : HCW'(4);
          hlen = (hcnt_d >= sep) ? hcnt_d - sep : '0;
          len  = post_d ? acc_d : 32'd0;
          for (int k = 3; k >= 0; k--) if (rc_d[k]) rt = 3'(k);
          res_v = 1'b1;
          if (hlen > HCW'(HEADER_LIMIT)) begin
            res_d.kind = KIND_DROP; res_d.verdict = VERDICT_MALFORMED;
            phase_d = PH_CLOSED;
          end else if (len > max_q) begin
            res_d.kind = KIND_DROP; res_d.verdict = VERDICT_TOO_LARGE;
            phase_d = PH_CLOSED;
          end else begin
            res_d.kind           = KIND_DESC;
            res_d.last_of_body   = (len == 32'd0);
            res_d.is_post        = post_d;
            res_d.route          = rt;
            res_d.content_length = len;
            res_d.compressed     = post_d && comp_d;
            res_d.keep_open      = post_d && keep_d;
            res_d.verdict        = (rt == ROUTE_UNKNOWN) ? VERDICT_NOT_FOUND
                                                         : VERDICT_DISPATCH;
            if (len == 32'd0) begin
              if (post_d && keep_d) restart = 1'b1;
              else phase_d = PH_CLOSED;
            end else begin
              phase_d = PH_BODY;
              rem_d   = len;
            end
          end
        end else if (hcnt_d > HCW'(HEADER_LIMIT + 3)) begin
          res_v = 1'b1;
          res_d.kind = KIND_DROP; res_d.verdict = VERDICT_MALFORMED;
          phase_d = PH_CLOSED;
        end else begin
          recent_d = {recent_d[15:0], c};
          if (phase_d == PH_HEADERS) begin
            if (c == CH_LF) begin
              vs_d = VS_NAME; hmask_d = 3'b111; hpos_d = '0;
            end else begin
              case (vs_d)
                VS_NAME: begin
                  if (!(hpos_d == 5'd0 && c == CH_CR)) begin
                    mask = hmask_d;
                    for (int k = 0; k < 3; k++)
                      if (!(hpos_d < name_len(2'(k)) && name_char(2'(k), hpos_d) == lc))
                        mask[k] = 1'b0;
                    pos = hpos_d + 5'd1;
                    hmask_d = mask;
                    hpos_d  = pos;
                    if (mask == 3'b000) begin
                      vs_d = VS_NONE;
                    end else begin
                      if (mask[0] && name_len(2'd0) == pos) begin
                        vs_d = VS_LEN_WS; acc_d = '0;
                      end
                      if (mask[1] && name_len(2'd1) == pos) vs_d = VS_ENC_WS;
                      if (mask[2] && name_len(2'd2) == pos) vs_d = VS_CONN_WS;
                    end
                  end
                end
                VS_LEN_WS, VS_LEN_DIG: begin
                  if (dig) begin
                    prod  = {acc_d, 3'b000} + {2'b00, acc_d, 1'b0} + 36'(c - 8'd48);
                    acc_d = (|prod[35:32]) ? 32'hFFFF_FFFF : prod[31:0];
                    vs_d  = VS_LEN_DIG;
                  end else if (!(ws && vs_d == VS_LEN_WS)) begin
                    vs_d = VS_NONE;
                  end
                end
                VS_ENC_WS: begin
                  if (!ws) begin
                    pp_d = 5'd1;
                    vs_d = (lc == 8'd103) ? VS_GZIP : ((lc == 8'd100) ? VS_DEFLATE : VS_NONE);
                  end
                end
                VS_CONN_WS: begin
                  if (!ws) begin
                    pp_d = 5'd1;
                    vs_d = (lc == 8'd99) ? VS_CLOSE : VS_NONE;
                  end
                end
                VS_GZIP, VS_DEFLATE, VS_CLOSE: begin
                  case (vs_d)
                    VS_GZIP: begin
                      wlen = 5'd4;
                      wch  = (pp_d < 5'd4) ? TXT_GZIP[8*(3 - 32'(pp_d)) +: 8] : 8'd0;
                    end
                    VS_DEFLATE: begin
                      wlen = 5'd7;
                      wch  = (pp_d < 5'd7) ? TXT_DEFLATE[8*(6 - 32'(pp_d)) +: 8] : 8'd0;
                    end
                    default: begin
                      wlen = 5'd5;
                      wch  = (pp_d < 5'd5) ? TXT_CLOSE[8*(4 - 32'(pp_d)) +: 8] : 8'd0;
                    end
                  endcase
                  if (pp_d < wlen && wch == lc) begin
                    pp_d = pp_d + 5'd1;
                    if (pp_d == wlen) begin
                      if (vs_d == VS_CLOSE) keep_d = 1'b0;
                      else comp_d = 1'b1;
                      vs_d = VS_NONE;
                    end
                  end else begin
                    vs_d = VS_NONE;
                  end
                end
                default: vs_d = VS_NONE;
              endcase
            end
          end else if (c == CH_LF) begin
            // End of the request line
            llen = lcnt_d - LCW'((prev == CH_CR && lcnt_d != '0) ? 1 : 0);
            if (llen >= LCW'(LINE_LIMIT) || phase_d == PH_METHOD) begin
              res_v = 1'b1;
              res_d.kind = KIND_DROP; res_d.verdict = VERDICT_MALFORMED;
              phase_d = PH_CLOSED;
            end else begin
              if (phase_d == PH_PATH)
                for (int k = 0; k < 4; k++)
                  if (route_len(2'(k)) != pp_d) rc_d[k] = 1'b0;
              phase_d = PH_HEADERS; vs_d = VS_NAME; hmask_d = 3'b111; hpos_d = '0;
            end
          end else begin
            lcnt_d = lcnt_d + 1'b1;
            if (lcnt_d > LCW'(LINE_LIMIT)) begin
              res_v = 1'b1;
              res_d.kind = KIND_DROP; res_d.verdict = VERDICT_MALFORMED;
              phase_d = PH_CLOSED;
            end else if (phase_d == PH_METHOD) begin
              if (c == CH_SP) begin
                if (mm_d == 3'd4) post_d = 1'b1;
                phase_d = PH_PATH; pp_d = '0; rc_d = 4'hF;
              end else if (mm_d < 3'd4 && post_char(mm_d) == c) begin
                mm_d = mm_d + 3'd1;
              end else begin
                mm_d = 3'd5;
              end
            end else if (phase_d == PH_PATH) begin
              if (prev == CH_CR) rc_d = 4'h0;
              stop = (c == CH_CR);
              if (!stop) begin
                if (c == CH_SP || c == CH_QM) begin
                  for (int k = 0; k < 4; k++)
                    if (route_len(2'(k)) != pp_d) rc_d[k] = 1'b0;
                  phase_d = PH_REST;
                end else begin
                  for (int k = 0; k < 4; k++)
                    if (!(pp_d < route_len(2'(k)) && route_char(2'(k), pp_d) == c))
                      rc_d[k] = 1'b0;
                  if (pp_d < 5'd31) pp_d = pp_d + 5'd1;
                end
              end
            end
          end
        end
      end
      PH_BODY: begin
        rem_d = rem_d - 32'd1;
        res_v = 1'b1;
        res_d.kind = KIND_BODY;
        res_d.body_byte = c;
        res_d.last_of_body = (rem_d == 32'd0);
        if (rem_d == 32'd0) begin
          if (post_d && keep_d) restart = 1'b1;
          else phase_d = PH_CLOSED;
        end
      end
      default: ;
    endcase

    // Start over for the next pipelined request
    if (restart) begin
      phase_d = PH_METHOD; recent_d = '0; hcnt_d = '0; lcnt_d = '0; mm_d = '0;
      rc_d = 4'hF; pp_d = '0; hmask_d = '0; hpos_d = '0; vs_d = VS_NONE;
      acc_d = '0; keep_d = 1'b1; comp_d = 1'b0; post_d = 1'b0; rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD; recent_q <= '0; hcnt_q <= '0; lcnt_q <= '0; mm_q <= '0;
      rc_q <= 4'hF; pp_q <= '0; hmask_q <= '0; hpos_q <= '0; vs_q <= VS_NONE;
      acc_q <= '0; keep_q <= 1'b1; comp_q <= 1'b0; post_q <= 1'b0; rem_q <= '0;
      max_q <= MAX_BODY_RESET;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) max_q <= cfg_i.data;
      if (accept) begin
        phase_q <= phase_d; recent_q <= recent_d; hcnt_q <= hcnt_d; lcnt_q <= lcnt_d;
        mm_q <= mm_d; rc_q <= rc_d; pp_q <= pp_d; hmask_q <= hmask_d; hpos_q <= hpos_d;
        vs_q <= vs_d; acc_q <= acc_d; keep_q <= keep_d; comp_q <= comp_d;
        post_q <= post_d; rem_q <= rem_d;
      end
      // Load a new word or drain the held one
      if (accept) ovalid_q <= res_v;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_v) odata_q <= res_d;
  end

endmodule

[design/hrp_checker.sv]
// Checker: port-level properties of the HTTP request parser, bound to the top level.
module hrp_checker
  import hrp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled output word changed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.kind != 2'd3)
    else $error("illegal result kind");

  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_BODY |->
      out_data_i.content_length == 32'd0 && !out_data_i.is_post &&
      out_data_i.verdict == VERDICT_DISPATCH)
    else $error("body word carries descriptor fields");

  a_desc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_DESC |->
      out_data_i.last_of_body == (out_data_i.content_length == 32'd0))
    else $error("descriptor last flag disagrees with length");

  a_drop_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_DROP |->
      out_data_i.verdict == VERDICT_TOO_LARGE || out_data_i.verdict == VERDICT_MALFORMED)
    else $error("drop word with non-error verdict");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
